@@ rtl/bpm_pkg.sv @@
// ----------------------------------------------------------------------------
// bpm_pkg
// Shared types and constants of the bracket pair matcher: character codes,
// outcome codes and the payload structs of the two streams.
// ----------------------------------------------------------------------------
package bpm_pkg;

  // field widths fixed by the stream format
  localparam int unsigned SymW = 8;
  localparam int unsigned PosW = 13;

  // default sizing
  localparam int unsigned MaxLenDef     = 4096;
  localparam int unsigned StackDepthDef = 2048;

  // characters that drive the stack
  localparam logic [SymW-1:0] SymOpen  = 8'h28;
  localparam logic [SymW-1:0] SymClose = 8'h29;

  // per-character outcome
  typedef enum logic [2:0] {
    OUT_UNPAIRED  = 3'd0,
    OUT_OPENED    = 3'd1,
    OUT_CLOSED    = 3'd2,
    OUT_UNMATCHED = 3'd3,
    OUT_FULL      = 3'd4,
    OUT_TOO_LONG  = 3'd5
  } outcome_e;

  // input character transaction
  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            last_symbol;
  } sym_t;

  // result transaction
  typedef struct packed {
    logic [PosW-1:0] position;
    logic [PosW-1:0] partner_position;
    outcome_e        outcome;
    logic            unclosed_at_end;
    logic            end_of_string;
  } res_t;

endpackage

@@ rtl/bpm_stream_if.sv @@
// ----------------------------------------------------------------------------
// bpm_stream_if
// Valid/ready stream carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface bpm_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

@@ rtl/bpm_ram.sv @@
// ----------------------------------------------------------------------------
// bpm_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module bpm_ram #(
  parameter int unsigned Width = 13,
  parameter int unsigned Depth = 2048,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bpm_skid.sv @@
// ----------------------------------------------------------------------------
// bpm_skid
// Two-entry output buffer: an output register plus a skid register, so the
// upstream side keeps accepting while a result waits at the output.
// ----------------------------------------------------------------------------
module bpm_skid #(
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  T     in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output T     out_data_o
);

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  T     out_q, out_d;
  T     skid_q, skid_d;
  logic in_txn;
  logic out_free;

  assign in_ready_o = !skid_valid_q;
  assign in_txn     = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || out_ready_i;

  // refill the output from the skid entry first, then from new data
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      out_valid_d  = skid_valid_q || in_txn;
      out_d        = skid_valid_q ? skid_q : in_data_i;
      skid_valid_d = 1'b0;
    end else if (in_txn) begin
      skid_d       = in_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/bracket_pair_matcher.sv @@
// ----------------------------------------------------------------------------
// bracket_pair_matcher
// Matches brackets of a dot-bracket string streamed one character per
// transaction, reporting for each character its position and partner.
//
//   port    dir  payload  meaning
//   sym_i   in   sym_t    one character, last flag on the final one
//   res_o   out  res_t    one result per character
//
// One character per cycle sustained unless the output stalls; results are
// registered in the output buffer. The top of stack sits in a register and
// the entry below it is prefetched from the stack RAM every cycle, with a
// bypass for the entry written in the previous cycle. After reset the block
// is ready at once, no clearing pass. The last flag returns the string state
// to empty. A stalled output first fills a skid register, then drops ready.
// ----------------------------------------------------------------------------
module bracket_pair_matcher
  import bpm_pkg::*;
#(
  parameter int unsigned MaxLen     = MaxLenDef,
  parameter int unsigned StackDepth = StackDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  bpm_stream_if.sink          sym_i,
  bpm_stream_if.source        res_o
);

  localparam int unsigned CntW  = $clog2(MaxLen + 1);
  localparam int unsigned SpW   = $clog2(StackDepth + 1);
  localparam int unsigned AddrW = (StackDepth > 1) ? $clog2(StackDepth) : 1;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [SpW-1:0]  sp_q, sp_d;
  logic [PosW-1:0] tos_q, tos_d;
  logic            fwd_q, fwd_d;
  logic [PosW-1:0] fwd_data_q;

  logic             in_txn;
  logic             buf_ready;
  sym_t             sym;
  res_t             res;
  logic [PosW-1:0]  below;
  logic [PosW-1:0]  ram_rdata;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [AddrW-1:0] ram_raddr;
  logic [31:0]      pos_wide;
  logic             too_long;
  logic             is_open;
  logic             is_close;
  logic             stack_empty;
  logic             stack_full;

  assign sym         = sym_i.data;
  assign sym_i.ready = buf_ready;
  assign in_txn      = sym_i.valid && buf_ready;

  assign too_long    = (cnt_q == CntW'(MaxLen));
  assign is_open     = (sym.symbol == SymOpen);
  assign is_close    = (sym.symbol == SymClose);
  assign stack_empty = (sp_q == '0);
  assign stack_full  = (sp_q == SpW'(StackDepth));
  assign pos_wide    = 32'(cnt_q) + 32'd1;

  // entry below the top: bypass a write from last cycle
  assign below = fwd_q ? fwd_data_q : ram_rdata;

  // character decode and stack update
  always_comb begin
    cnt_d     = cnt_q;
    sp_d      = sp_q;
    tos_d     = tos_q;
    fwd_d     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = AddrW'(sp_q - SpW'(1));

    res.position         = '0;
    res.partner_position = '0;
    res.outcome          = OUT_UNPAIRED;
    res.unclosed_at_end  = 1'b0;
    res.end_of_string    = sym.last_symbol;

    if (too_long) begin
      res.outcome = OUT_TOO_LONG;
    end else begin
      cnt_d        = cnt_q + CntW'(1);
      res.position = pos_wide[PosW-1:0];
      if (is_open) begin
        if (stack_full) begin
          res.outcome = OUT_FULL;
        end else begin
          res.outcome = OUT_OPENED;
          sp_d        = sp_q + SpW'(1);
          tos_d       = pos_wide[PosW-1:0];
          // spill the old top to the RAM
          if (!stack_empty) begin
            ram_we = in_txn;
            fwd_d  = in_txn && !sym.last_symbol;
          end
        end
      end else if (is_close) begin
        if (stack_empty) begin
          res.outcome = OUT_UNMATCHED;
        end else begin
          res.outcome          = OUT_CLOSED;
          res.partner_position = tos_q;
          sp_d                 = sp_q - SpW'(1);
          tos_d                = below;
        end
      end
    end

    res.unclosed_at_end = sym.last_symbol && (sp_d != '0);

    // end of string empties the state
    if (sym.last_symbol) begin
      cnt_d = '0;
      sp_d  = '0;
    end

    // hold everything when no transaction
    if (!in_txn) begin
      cnt_d = cnt_q;
      sp_d  = sp_q;
      tos_d = tos_q;
    end
  end

  // prefetch the entry below the next top
  assign ram_raddr = AddrW'(sp_d - SpW'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sp_q  <= '0;
      fwd_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      sp_q  <= sp_d;
      fwd_q <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q      <= tos_d;
    fwd_data_q <= tos_q;
  end

  // stack storage below the top entry
  bpm_ram #(
    .Width (PosW),
    .Depth (StackDepth)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (tos_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result buffering
  bpm_skid #(
    .T (res_t)
  ) u_res_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_txn),
    .in_ready_o  (buf_ready),
    .in_data_i   (res),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_data_o  (res_o.data)
  );

  // checks
  a_sp_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpW'(StackDepth))
    else $error("stack pointer beyond depth");

  a_fwd_deep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> (sp_q >= SpW'(2)))
    else $error("bypass active with fewer than two entries");

  a_last_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_txn && sym.last_symbol) |=> (sp_q == '0 && cnt_q == '0))
    else $error("string state not cleared after last character");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sym_i.ready |-> res_o.valid)
    else $error("input stalled with no result pending");

endmodule

@@ verif/bracket_pair_matcher_tb.sv @@
// ----------------------------------------------------------------------------
// bracket_pair_matcher_tb
// Streams dot-bracket strings into the matcher and checks every result
// transaction against a behavioural predictor of the position counter and
// the open-bracket stack. Covers directed corner cases, random well-formed
// and broken strings, a full drain mid-run, and one string long enough to
// overflow the stack and run past the maximum length. Both stream sides
// idle at random.
// ----------------------------------------------------------------------------
module bracket_pair_matcher_tb;
  import bpm_pkg::*;

  localparam int unsigned MaxLen      = MaxLenDef;
  localparam int unsigned StackDepth  = StackDepthDef;
  localparam int unsigned HalfPeriod  = 5;
  localparam int unsigned ResetCycles = 8;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned RandomItems = 1000;
  localparam int unsigned CycleLimit  = 2000000;
  localparam int unsigned ReportLimit = 10;
  localparam logic [SymW-1:0] SymDot  = 8'h2E;

  logic clk_i = 1'b0;
  logic rst_ni;

  bpm_stream_if #(.payload_t(sym_t)) sym_if ();
  bpm_stream_if #(.payload_t(res_t)) res_if ();

  bracket_pair_matcher #(
    .MaxLen     (MaxLen),
    .StackDepth (StackDepth)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sym_i  (sym_if),
    .res_o  (res_if)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // predictor state for the current string
  int unsigned       chars_seen;
  int unsigned       open_count;
  logic [PosW-1:0]   open_positions [StackDepth];

  // results still to arrive, oldest first
  res_t              match_reports [$];

  int unsigned       failures;
  int unsigned       cycle_count;
  int unsigned       quiet_left;

  // work out the result of one character and advance the string state
  function automatic res_t match_symbol(sym_t item);
    res_t r;
    r = '0;
    if (chars_seen >= MaxLen) begin
      r.outcome = OUT_TOO_LONG;
    end else begin
      chars_seen++;
      r.position = PosW'(chars_seen);
      if (item.symbol == SymOpen) begin
        if (open_count < StackDepth) begin
          open_positions[open_count] = r.position;
          open_count++;
          r.outcome = OUT_OPENED;
        end else begin
          r.outcome = OUT_FULL;
        end
      end else if (item.symbol == SymClose) begin
        if (open_count != 0) begin
          open_count--;
          r.partner_position = open_positions[open_count];
          r.outcome = OUT_CLOSED;
        end else begin
          r.outcome = OUT_UNMATCHED;
        end
      end else begin
        r.outcome = OUT_UNPAIRED;
      end
    end
    r.end_of_string   = item.last_symbol;
    r.unclosed_at_end = item.last_symbol && (open_count != 0);
    // last character clears the string state
    if (item.last_symbol) begin
      chars_seen = 0;
      open_count = 0;
    end
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic void note_failure(string msg);
    failures++;
    if (failures <= ReportLimit) begin
      $display("mismatch: %s", msg);
    end
  endfunction

  // one character transaction, predicted on acceptance
  task automatic send_symbol(input logic [SymW-1:0] ch, input logic last);
    sym_t        item;
    int unsigned gap;
    item.symbol      = ch;
    item.last_symbol = last;
    sym_if.valid <= 1'b1;
    sym_if.data  <= item;
    @(posedge clk_i);
    while (!sym_if.ready) @(posedge clk_i);
    match_reports = {match_reports, match_symbol(item)};
    // random idling, with quiet stretches now and then
    if (quiet_left != 0) begin
      quiet_left--;
      gap = 0;
    end else begin
      gap = idle_gap();
      if ($urandom_range(0, 19) == 0) quiet_left = $urandom_range(10, 60);
    end
    if (gap != 0) begin
      sym_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_text(input string text);
    for (int k = 0; k < text.len(); k++) begin
      send_symbol(text[k], k == text.len() - 1);
    end
  endtask

  task automatic wait_reports_drained();
    sym_if.valid <= 1'b0;
    while (match_reports.size() != 0) @(posedge clk_i);
  endtask

  // extremes of the character, every outcome but the overflow ones
  task automatic test_directed_cases();
    send_symbol(SymClose, 1'b1);
    send_symbol(SymOpen, 1'b1);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(SymOpen, 1'b0);
    send_symbol(SymOpen, 1'b0);
    send_symbol(8'h27, 1'b0);
    send_symbol(SymClose, 1'b0);
    send_symbol(8'h2A, 1'b0);
    send_symbol(SymClose, 1'b0);
    send_symbol(SymClose, 1'b1);
    send_text("((x)");
    send_text("()");
    send_text(".");
  endtask

  // random strings: mostly balanced with random filler, some noise
  task automatic test_random_strings();
    logic [SymW-1:0] text [$];
    logic [SymW-1:0] ch;
    int unsigned     sent;
    int unsigned     kind;
    int unsigned     len;
    int unsigned     depth;
    int unsigned     r;
    sent = 0;
    while (sent < RandomItems) begin
      text.delete();
      kind  = $urandom_range(0, 9);
      len   = (kind == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      depth = 0;
      if (kind <= 6) begin
        // balanced; the long kind tends to nest deep
        while (text.size() < len) begin
          if (depth != 0 && $urandom_range(0, 2) == 0) begin
            text = {text, SymClose};
            depth--;
          end else if ($urandom_range(0, 2) != 0) begin
            text = {text, SymOpen};
            depth++;
          end else begin
            ch = $urandom_range(0, 1) ? SymDot : 8'($urandom_range(0, 255));
            if (ch == SymOpen || ch == SymClose) ch = SymDot;
            text = {text, ch};
          end
        end
        repeat (depth) text = {text, SymClose};
      end else begin
        // broken: stray closes, dangling opens, any byte
        repeat (len) begin
          r  = $urandom_range(0, 9);
          ch = (r < 4) ? SymOpen : (r < 8) ? SymClose : 8'($urandom_range(0, 255));
          text = {text, ch};
        end
      end
      foreach (text[k]) send_symbol(text[k], k == text.size() - 1);
      sent += text.size();
    end
  endtask

  // sender holds off until every result is back, between strings
  task automatic test_pause_until_drained();
    send_text("(a(b)c)");
    wait_reports_drained();
    send_text("((((");
    wait_reports_drained();
    send_text("))(");
    wait_reports_drained();
  endtask

  // one string that overflows the stack and then runs past the length limit
  task automatic test_stack_full_and_overlength();
    for (int unsigned k = 0; k <= StackDepth; k++) send_symbol(SymOpen, 1'b0);
    // closes pair with the opens that did get pushed
    repeat (3) send_symbol(SymClose, 1'b0);
    for (int unsigned k = StackDepth + 4; k < MaxLen; k++) send_symbol(SymDot, 1'b0);
    // every further character is over length, last flag still honoured
    send_symbol(SymOpen, 1'b0);
    send_symbol(SymClose, 1'b0);
    send_symbol(8'hFF, 1'b1);
    send_text("()");
  endtask

  // result side: ready with random stalls and stall-free stretches
  initial begin : result_sink
    int unsigned run;
    int unsigned stall;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    res_if.ready <= 1'b1;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 100) : $urandom_range(1, 4);
      repeat (run) @(posedge clk_i);
      stall = idle_gap();
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin : result_check
    res_t got;
    res_t want;
    if (rst_ni === 1'b1 && res_if.valid && res_if.ready) begin
      got = res_if.data;
      if (match_reports.size() == 0) begin
        note_failure($sformatf("unexpected result at position %0d", got.position));
      end else begin
        want = match_reports.pop_front();
        if (got.position !== want.position ||
            got.partner_position !== want.partner_position ||
            got.outcome !== want.outcome ||
            got.unclosed_at_end !== want.unclosed_at_end ||
            got.end_of_string !== want.end_of_string) begin
          note_failure($sformatf(
            "expected pos %0d partner %0d outcome %0d unclosed %b end %b, got pos %0d partner %0d outcome %0d unclosed %b end %b",
            want.position, want.partner_position, want.outcome,
            want.unclosed_at_end, want.end_of_string,
            got.position, got.partner_position, got.outcome,
            got.unclosed_at_end, got.end_of_string));
        end
      end
    end
  end

  // cycle limit
  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CycleLimit; cycle_count++) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  initial begin : main_sequence
    failures   = 0;
    quiet_left = 0;
    chars_seen = 0;
    open_count = 0;
    sym_if.valid <= 1'b0;
    sym_if.data  <= '0;
    rst_ni       <= 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_random_strings();
    test_pause_until_drained();
    test_stack_full_and_overlength();

    // let the pipeline empty, then allow for stray results
    wait_reports_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bpm_pkg.sv
rtl/bpm_stream_if.sv
rtl/bpm_ram.sv
rtl/bpm_skid.sv
rtl/bracket_pair_matcher.sv
verif/bracket_pair_matcher_tb.sv
